FILE: sv/lru_pfc_pkg.sv
// Shared package for the LRU page fault counter.
// Holds the fixed field widths, the reset value of the capacity register and the
// command and status structs between controller and datapath. No dependencies.
package lru_pfc_pkg;

	// Fixed widths of the interface fields.
	localparam int PAGE_W  = 16;
	localparam int CAP_W   = 5;
	localparam int COUNT_W = 32;

	// Capacity after reset and the saturation value of the fault count.
	localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // take one input beat and register its result
		logic clear;    // the beat ends its sequence: empty store and count afterwards
		logic cfg_wr;   // write the capacity register
	} ctrl_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic resident; // at least one frame holds a page
		logic full;     // occupancy has reached the effective capacity
	} dp_sts_t;

endpackage

FILE: sv/lru_page_fault_counter_top.sv
// LRU page fault counter, top level. A result appears in the cycle after its beat.
// Throughput: one beat per cycle when not stalled; cells compare and shift in parallel.
// A beat is taken while a result waits, unless that result is stalled.
// Reset empties the store, zeroes the count and sets capacity to 16; no clearing pass.
// Depends on lru_pfc_pkg, lru_pfc_ctrl and lru_pfc_dp.
module lru_page_fault_counter_top
	import lru_pfc_pkg::*;
#(
	parameter int ENTRIES   = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PAGE_W-1:0]  page,
	input  logic               last_request,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               fault,
	output logic [COUNT_W-1:0] fault_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CAP_W-1:0]   capacity
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	lru_pfc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.last_request (last_request),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cmd          (cmd)
	);

	lru_pfc_dp #(
		.ENTRIES   (ENTRIES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.page        (page),
		.capacity    (capacity),
		.sts         (sts),
		.fault       (fault),
		.fault_count (fault_count)
	);

	// A beat that ends its sequence leaves the store empty.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> !sts.resident)
		else $error("store not empty after sequence end");

	// A fault result always carries a nonzero count.
	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> fault_count != '0)
		else $error("fault with zero count");

	// Any accepted beat that is not a sequence end leaves at least one page resident.
	a_page_resident: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !cmd.clear |=> sts.resident && out_valid)
		else $error("accepted page not resident");

	// A reference to an empty store is always a fault.
	a_fill_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && !cmd.clear && !sts.resident |=> fault)
		else $error("miss on empty store not flagged");

endmodule

FILE: sv/lru_pfc_dp.sv
// Datapath of the LRU page fault counter: recency-ordered frame cells with a
// parallel compare, occupancy, capacity register, fault count and result register.
// Depends on lru_pfc_pkg.
module lru_pfc_dp
	import lru_pfc_pkg::*;
#(
	parameter int ENTRIES   = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  logic [PAGE_W-1:0]  page,
	input  logic [CAP_W-1:0]   capacity,
	output dp_sts_t            sts,
	output logic               fault,
	output logic [COUNT_W-1:0] fault_count
);

	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int EXT_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [PAGE_BITS-1:0] cells_q [ENTRIES];
	logic [OCC_W-1:0]     occ_q;
	logic [CAP_W-1:0]     cap_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 fault_q;
	logic [COUNT_W-1:0]   count_out_q;

	logic [PAGE_BITS-1:0] pg;
	logic [ENTRIES-1:0]   match;
	logic                 hit;
	logic [POS_W-1:0]     hit_pos;
	logic [EXT_W-1:0]     cap_ext;
	logic [EXT_W-1:0]     cap_eff;
	logic                 room;
	logic [OCC_W-1:0]     upto;
	logic [COUNT_W-1:0]   count_next;

	// Only the low PAGE_BITS bits of the page number take part.
	assign pg = PAGE_BITS'(page);

	// Capacity of zero acts as one, anything above the built size as the built size.
	always_comb begin
		cap_ext = EXT_W'(cap_q);
		if (cap_ext == '0) begin
			cap_eff = EXT_W'(1);
		end else if (cap_ext > EXT_W'(ENTRIES)) begin
			cap_eff = EXT_W'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign room = EXT_W'(occ_q) < cap_eff;

	// Compare every occupied cell against the page at once.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (cells_q[i] == pg) && (OCC_W'(i) < occ_q);
		end
	end

	// The most recent matching cell wins.
	always_comb begin
		hit_pos = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_pos = POS_W'(i);
			end
		end
	end

	assign hit = |match;

	// Last cell that takes part in the shift toward the least recent end.
	always_comb begin
		if (hit) begin
			upto = OCC_W'(hit_pos);
		end else if (room) begin
			upto = occ_q;
		end else begin
			upto = occ_q - OCC_W'(1);
		end
	end

	// Faults count up and stop at the top.
	assign count_next = (!hit && (count_q != COUNT_MAX)) ? count_q + COUNT_W'(1) : count_q;

	// Most recent cell always takes the referenced page.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cells_q[0] <= pg;
		end
	end

	// Older cells move down one place up to the shift limit.
	for (genvar g = 1; g < ENTRIES; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.load && (OCC_W'(g) <= upto)) begin
				cells_q[g] <= cells_q[g-1];
			end
		end
	end

	// Occupancy and running count; a sequence end empties both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
		end else if (cmd.load) begin
			if (cmd.clear) begin
				occ_q   <= '0;
				count_q <= '0;
			end else begin
				if (!hit && room) begin
					occ_q <= occ_q + OCC_W'(1);
				end
				count_q <= count_next;
			end
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cmd.cfg_wr) begin
			cap_q <= capacity;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fault_q     <= !hit;
			count_out_q <= count_next;
		end
	end

	assign fault        = fault_q;
	assign fault_count  = count_out_q;
	assign sts.resident = occ_q != '0;
	assign sts.full     = !room;

endmodule

FILE: sv/lru_pfc_ctrl.sv
// Controller of the LRU page fault counter: handshake state machine that owns
// the result register's valid and issues datapath commands.
// Depends on lru_pfc_pkg.
module lru_pfc_ctrl
	import lru_pfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      last_request,
	output logic      out_valid,
	input  logic      out_stall,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	output ctrl_cmd_t cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_HOLD  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// A new beat enters unless a held result is still stalled.
	assign in_stall  = (state_q == ST_HOLD) && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = state_q == ST_HOLD;
	assign cfg_ready = 1'b1;

	assign cmd.load   = accept;
	assign cmd.clear  = accept && last_request;
	assign cmd.cfg_wr = cfg_valid;

	// Next state of the result register.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (accept) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_stall && !accept) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sim/lru_fault_checker.sv
// Checker for the LRU page fault counter: watches the page, result and capacity channels.
// Keeps its own recency-ordered copy of the page store, predicts each result and compares.
// Depends on lru_pfc_pkg.
module lru_fault_checker
	import lru_pfc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [PAGE_W-1:0]  page,
	input  logic               last_request,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               fault,
	input  logic [COUNT_W-1:0] fault_count,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CAP_W-1:0]   capacity,
	output int                 mismatches,
	output int                 pending,
	output int                 refs_seen,
	output int                 faults_seen,
	output int                 evictions_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               fault;
		logic [COUNT_W-1:0] fault_count;
	} lru_result_t;

	// Shadow of the block: pages in recency order, position 0 most recent.
	logic [PAGE_W-1:0]  frames [ENTRIES];
	int unsigned        occupancy;
	logic [COUNT_W-1:0] seq_faults;
	logic [CAP_W-1:0]   cap_reg;
	lru_result_t        expected_results [$];

	initial begin
		mismatches = 0;
		pending = 0;
		refs_seen = 0;
		faults_seen = 0;
		evictions_seen = 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: MISMATCH %s", $realtime, what);
		mismatches++;
	endtask

	// Apply one page reference to the shadow store and queue the result it yields.
	function automatic void reference_page(input logic [PAGE_W-1:0] pg, input logic lst);
		int unsigned eff_cap;
		int unsigned hit_pos;
		int unsigned upto;
		bit          hit;
		lru_result_t res;
		eff_cap = cap_reg;
		if (eff_cap == 0) eff_cap = 1;
		if (eff_cap > ENTRIES) eff_cap = ENTRIES;
		if (occupancy > ENTRIES) occupancy = ENTRIES;
		hit = 1'b0;
		hit_pos = 0;
		for (int i = 0; i < occupancy; i++) begin
			if (!hit && frames[i] == pg) begin
				hit = 1'b1;
				hit_pos = i;
			end
		end
		// A hit moves the page to the front; a miss either grows the store or
		// drops only the single least recent frame, even if capacity was lowered.
		if (hit) begin
			upto = hit_pos;
		end else if (occupancy < eff_cap) begin
			upto = occupancy;
			occupancy++;
		end else begin
			upto = occupancy - 1;
			evictions_seen++;
		end
		if (upto >= ENTRIES) upto = ENTRIES - 1;
		for (int i = upto; i > 0; i--) frames[i] = frames[i-1];
		frames[0] = pg;
		if (!hit && seq_faults != COUNT_MAX) seq_faults++;
		if (!hit) faults_seen++;
		res.fault = !hit;
		res.fault_count = seq_faults;
		expected_results.push_back(res);
		refs_seen++;
		// The end of a reference string empties the store after its result.
		if (lst) begin
			occupancy = 0;
			seq_faults = '0;
		end
	endfunction

	// Sample every channel at the clock edge, before the drivers update.
	always @(posedge clk or negedge arst_n) begin
		lru_result_t want;
		if (!arst_n) begin
			occupancy = 0;
			seq_faults = '0;
			cap_reg = CAP_RESET;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) cap_reg = capacity;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result beat fault=%0b count=%0d with none outstanding",
						fault, fault_count));
				end else begin
					want = expected_results.pop_front();
					if (fault !== want.fault)
						report_mismatch($sformatf("fault got %0b want %0b",
							fault, want.fault));
					if (fault_count !== want.fault_count)
						report_mismatch($sformatf("fault_count got %0d want %0d",
							fault_count, want.fault_count));
				end
			end
			if (in_valid && !in_stall) reference_page(page, last_request);
		end
		pending = expected_results.size();
	end

endmodule

FILE: sim/lru_page_fault_counter_top_tb.sv
// Testbench top for the LRU page fault counter: clock, reset, stimulus and verdict.
// Drives page references and capacity writes; checking is done in lru_fault_checker.
// Depends on lru_pfc_pkg, lru_page_fault_counter_top and lru_fault_checker.
module lru_page_fault_counter_top_tb
	import lru_pfc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES      = 16;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_REFS   = 110;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [PAGE_W-1:0]  page = '0;
	logic               last_request = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               fault;
	logic [COUNT_W-1:0] fault_count;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CAP_W-1:0]   capacity = CAP_RESET;

	int mismatches;
	int pending;
	int refs_seen;
	int faults_seen;
	int evictions_seen;
	int cap_writes = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	int stall_mode = 0;
	int stall_timer = 0;

	always #5 clk = ~clk;

	lru_page_fault_counter_top #(
		.ENTRIES(ENTRIES),
		.PAGE_BITS(PAGE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.page(page),
		.last_request(last_request),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fault(fault),
		.fault_count(fault_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.capacity(capacity)
	);

	lru_fault_checker #(
		.ENTRIES(ENTRIES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.page(page),
		.last_request(last_request),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fault(fault),
		.fault_count(fault_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.capacity(capacity),
		.mismatches(mismatches),
		.pending(pending),
		.refs_seen(refs_seen),
		.faults_seen(faults_seen),
		.evictions_seen(evictions_seen)
	);

	// Result stall pattern: a new mode each time a random timer runs out, from never
	// stalling through light and heavy random stalls to a strict alternation.
	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_timer <= $urandom_range(10, 60);
		end else begin
			stall_timer <= stall_timer - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 25);
			2: out_stall <= ($urandom_range(0, 99) < 70);
			default: out_stall <= ~out_stall;
		endcase
	end

	// Watchdog: too long without a beat on any channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout after %0d cycles without a beat.", QUIET_LIMIT);
				$display("lru_page_fault_counter_top_tb NOT OK");
				$finish;
			end
		end
	end

	// Offer one page reference and hold it until taken; bursts end in a random gap.
	task automatic issue_ref(input logic [PAGE_W-1:0] pg, input logic lst);
		int gap;
		in_valid <= 1'b1;
		page <= pg;
		last_request <= lst;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every outstanding result has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Capacity is only written while the block holds no work.
	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		capacity <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	initial begin : stimulus
		logic [CAP_W-1:0]  cap_list [8];
		logic [PAGE_W-1:0] pool [24];
		logic [PAGE_W-1:0] pg;
		int                eff_cap;
		int                pool_n;
		int                seq_len;
		int                phase_refs;
		logic              lst;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: extreme pages, hits in the middle and at the least recent slot.
		issue_ref(16'h0000, 1'b0);
		issue_ref(16'hFFFF, 1'b0);
		issue_ref(16'h0000, 1'b0);
		issue_ref(16'h1234, 1'b0);
		issue_ref(16'hFFFF, 1'b0);
		issue_ref(16'h1234, 1'b1);

		// Small store: fill it, then evict on every new page, then a hit.
		write_capacity(5'd3);
		issue_ref(16'hA000, 1'b0);
		issue_ref(16'hA001, 1'b0);
		issue_ref(16'hA002, 1'b0);
		issue_ref(16'hA003, 1'b0);
		issue_ref(16'hA000, 1'b0);
		issue_ref(16'hA002, 1'b0);

		// Capacity lowered below the occupancy: a miss drops one frame only.
		write_capacity(5'd1);
		issue_ref(16'h5555, 1'b0);
		issue_ref(16'hA000, 1'b0);
		issue_ref(16'h5555, 1'b1);

		// Zero capacity behaves as a single frame.
		write_capacity(5'd0);
		issue_ref(16'h00FF, 1'b0);
		issue_ref(16'h00FF, 1'b0);
		issue_ref(16'hFF00, 1'b0);
		issue_ref(16'h00FF, 1'b1);

		// Capacity beyond the built store is clipped to the full size.
		write_capacity(5'd31);
		issue_ref(16'h7FFF, 1'b0);
		issue_ref(16'h8000, 1'b0);
		issue_ref(16'h7FFF, 1'b1);

		// Random phases: reference strings over a working set sized around the
		// capacity, with some stray pages and early sequence ends. A phase may end
		// mid-string, so the next capacity applies to a partly filled store.
		cap_list = '{5'd16, 5'd2, 5'd5, 5'd0, 5'd31, 5'd12, 5'd1, 5'd7};
		cap_list[7] = CAP_W'($urandom_range(0, 31));
		for (int ph = 0; ph < 8; ph++) begin
			write_capacity(cap_list[ph]);
			eff_cap = (cap_list[ph] == 0) ? 1
				: (cap_list[ph] > ENTRIES ? ENTRIES : int'(cap_list[ph]));
			phase_refs = 0;
			while (phase_refs < PHASE_REFS) begin
				if ($urandom_range(0, 3) == 0)
					pool_n = $urandom_range(1, eff_cap);
				else
					pool_n = eff_cap + $urandom_range(0, 4);
				for (int k = 0; k < pool_n; k++) begin
					case ($urandom_range(0, 15))
						0: pool[k] = 16'h0000;
						1: pool[k] = 16'hFFFF;
						default: pool[k] = PAGE_W'($urandom);
					endcase
				end
				seq_len = $urandom_range(1, 40);
				for (int n = 0; n < seq_len && phase_refs < PHASE_REFS; n++) begin
					if ($urandom_range(0, 99) < 8)
						pg = PAGE_W'($urandom);
					else
						pg = pool[$urandom_range(0, pool_n - 1)];
					lst = (n == seq_len - 1) || ($urandom_range(0, 99) < 3);
					issue_ref(pg, lst);
					phase_refs++;
				end
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Checked %0d page references: %0d faults, %0d evictions.",
			refs_seen, faults_seen, evictions_seen);
		$display("Capacity was rewritten %0d times, including 0, 1, 16 and 31.", cap_writes);
		if (mismatches == 0) begin
			$display("lru_page_fault_counter_top_tb OK");
		end else begin
			$display("%0d mismatches found.", mismatches);
			$display("lru_page_fault_counter_top_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/lru_pfc_pkg.sv
sv/lru_pfc_dp.sv
sv/lru_pfc_ctrl.sv
sv/lru_page_fault_counter_top.sv
sim/lru_fault_checker.sv
sim/lru_page_fault_counter_top_tb.sv
